@@ rtl/multi_pattern_byte_matcher_macros.svh @@
// Assertion macros for the multi-pattern byte matcher.
// Define NO_ASSERTIONS to compile every use down to nothing.
`ifndef MULTI_PATTERN_BYTE_MATCHER_MACROS_SVH
`define MULTI_PATTERN_BYTE_MATCHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent and consequent in the same cycle.
`define MPBM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("multi_pattern_byte_matcher: assertion failed");

// Consequent in the cycle after the antecedent.
`define MPBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("multi_pattern_byte_matcher: assertion failed");

`else

`define MPBM_ASSERT_IMPL(label, ante, cons)
`define MPBM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/mpbm_pkg.sv @@
package mpbm_pkg;

    localparam int MASK_BITS = 16;
    localparam int IDX_W     = 4;
    localparam int POS_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int PLEN_W    = 7;

    typedef enum logic [1:0] {
        ACT_LOAD_BYTE = 2'd0,
        ACT_SET_LEN   = 2'd1,
        ACT_SCAN      = 2'd2,
        ACT_CLOSE     = 2'd3
    } t_action;

    // One byte write into a per-pattern column of a cell.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } t_pat_wr;

endpackage

@@ rtl/multi_pattern_byte_matcher.sv @@
// Multi-pattern byte matcher. Up to sixteen byte patterns of up to
// MAX_PATTERN_LEN bytes are loaded by transfers, and data bytes streamed in
// are compared with every enabled pattern at once by a row of
// MAX_PATTERN_LEN cells, each holding one window byte and one pattern column.
// Every kind of input transfer is taken at one per clock cycle while the
// input channel is not stalled. The compare for a data byte runs in the cycle
// after its transfer, and a pattern load or length write is realigned into
// the cells by one shared shifter in the cycle after its transfer; both are
// hidden, so any item may follow any other directly. A close transfer places
// the found mask in the output register, visible from the next cycle; while
// that register is full and stalled the input channel stalls too.
`include "multi_pattern_byte_matcher_macros.svh"

module multi_pattern_byte_matcher
    import mpbm_pkg::*;
#(
    parameter int NUM_PATTERNS    = 16,
    parameter int MAX_PATTERN_LEN = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_action,
    input  logic [IDX_W-1:0]     i_pattern_index,
    input  logic [POS_W-1:0]     i_byte_position,
    input  logic [BYTE_W-1:0]    i_byte_value,
    input  logic [PLEN_W-1:0]    i_pattern_length,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [MASK_BITS-1:0] o_found_mask
);

    localparam int M   = MAX_PATTERN_LEN;
    localparam int NP  = (NUM_PATTERNS < MASK_BITS) ? NUM_PATTERNS : MASK_BITS;
    localparam int LW  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int PIW = (NP > 1) ? $clog2(NP) : 1;

    t_action act;
    logic    in_acc, idx_ok, load_acc, len_acc, scan_acc, close_acc;
    logic [PIW-1:0] idx;
    logic [LW-1:0]  len_sat;

    logic [NP-1:0][LW-1:0] r_len, r_alen;
    logic                  r_rl_go;
    logic [PIW-1:0]        r_rl_idx;
    logic [LW-1:0]         r_seen, n_seen;
    logic                  r_cmp_go;
    logic [MASK_BITS-1:0]  r_flags, n_flags;
    logic                  r_out_valid;
    logic [MASK_BITS-1:0]  r_out_mask;

    t_pat_wr                 raw_wr;
    logic [M-1:0][BYTE_W-1:0] win_bytes, raw_row, al_row;
    logic [M-1:0][NP-1:0]    ok;
    logic [NP-1:0]           all_ok, hits;
    logic [MASK_BITS-1:0]    hit_mask;

    assign o_stall   = r_out_valid && i_stall;
    assign in_acc    = i_valid && !o_stall;
    assign act       = t_action'(i_action);
    assign idx_ok    = 32'(i_pattern_index) < NP;
    assign idx       = i_pattern_index[PIW-1:0];
    assign load_acc  = in_acc && (act == ACT_LOAD_BYTE) && idx_ok;
    assign len_acc   = in_acc && (act == ACT_SET_LEN) && idx_ok;
    assign scan_acc  = in_acc && (act == ACT_SCAN);
    assign close_acc = in_acc && (act == ACT_CLOSE);

    assign len_sat = (32'(i_pattern_length) > MAX_PATTERN_LEN) ?
                     LW'(MAX_PATTERN_LEN) : LW'(i_pattern_length);

    always_comb begin
        raw_wr.en   = load_acc;
        raw_wr.idx  = i_pattern_index;
        raw_wr.data = i_byte_value;
    end

    genvar j;
    generate
        for (j = 0; j < M; j++) begin : g_cell
            t_pat_wr             al_wr;
            logic [BYTE_W-1:0]   prev_byte;

            if (j == 0) begin : g_head
                assign prev_byte = i_byte_value;
            end else begin : g_link
                assign prev_byte = win_bytes[j-1];
            end

            always_comb begin
                al_wr.en   = r_rl_go;
                al_wr.idx  = IDX_W'(r_rl_idx);
                al_wr.data = al_row[j];
            end

            mpbm_cell #(
                .NP  (NP),
                .POS (j),
                .LW  (LW)
            ) u_cell (
                .i_clk    (i_clk),
                .i_shift  (scan_acc),
                .i_byte   (prev_byte),
                .o_byte   (win_bytes[j]),
                .i_raw_wr (raw_wr),
                .i_pos    (i_byte_position),
                .i_rd_idx (IDX_W'(r_rl_idx)),
                .o_raw    (raw_row[j]),
                .i_al_wr  (al_wr),
                .i_alen   (r_alen),
                .o_ok     (ok[j])
            );
        end
    endgenerate

    // Realigns the pattern touched by the previous transfer.
    mpbm_align #(
        .M  (M),
        .LW (LW)
    ) u_align (
        .i_row (raw_row),
        .i_len (r_len[r_rl_idx]),
        .o_row (al_row)
    );

    always_comb begin
        all_ok = '1;
        for (int k = 0; k < M; k++) begin
            all_ok &= ok[k];
        end
        for (int p = 0; p < NP; p++) begin
            hits[p] = r_cmp_go && all_ok[p] && (r_alen[p] != '0) &&
                      (r_alen[p] <= r_seen);
        end
        hit_mask = MASK_BITS'(hits);
    end

    always_comb begin
        n_seen = r_seen;
        if (close_acc) begin
            n_seen = '0;
        end else if (scan_acc && (r_seen != LW'(MAX_PATTERN_LEN))) begin
            n_seen = r_seen + LW'(1);
        end
        n_flags = close_acc ? '0 : (r_flags | hit_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_alen      <= '0;
            r_rl_go     <= 1'b0;
            r_seen      <= '0;
            r_cmp_go    <= 1'b0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (len_acc) begin
                r_len[idx] <= len_sat;
            end
            if (r_rl_go) begin
                r_alen[r_rl_idx] <= r_len[r_rl_idx];
            end
            r_rl_go  <= load_acc || len_acc;
            r_seen   <= n_seen;
            r_cmp_go <= scan_acc;
            r_flags  <= n_flags;
            if (close_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rl_idx <= idx;
        if (close_acc) begin
            r_out_mask <= r_flags | hit_mask;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found_mask = r_out_mask;

    `MPBM_ASSERT_NEXT(a_close_clears, close_acc, (r_seen == '0) && (r_flags == '0))
    `MPBM_ASSERT_NEXT(a_load_realigns, load_acc || len_acc, r_rl_go)
    `MPBM_ASSERT_IMPL(a_cmp_follows_scan, r_cmp_go, $past(scan_acc))

endmodule

@@ rtl/mpbm_cell.sv @@
module mpbm_cell
    import mpbm_pkg::*;
#(
    parameter int NP  = 16,
    parameter int POS = 0,
    parameter int LW  = 7
) (
    input  logic                     i_clk,
    input  logic                     i_shift,
    input  logic [BYTE_W-1:0]        i_byte,
    output logic [BYTE_W-1:0]        o_byte,
    input  t_pat_wr                  i_raw_wr,
    input  logic [POS_W-1:0]         i_pos,
    input  logic [IDX_W-1:0]         i_rd_idx,
    output logic [BYTE_W-1:0]        o_raw,
    input  t_pat_wr                  i_al_wr,
    input  logic [NP-1:0][LW-1:0]    i_alen,
    output logic [NP-1:0]            o_ok
);

    localparam int PIW = (NP > 1) ? $clog2(NP) : 1;

    // Window byte at this distance from the newest byte.
    logic [BYTE_W-1:0] r_win;
    // Pattern byte at position POS of every pattern, as loaded.
    logic [BYTE_W-1:0] r_raw [NP];
    // Pattern byte that lines up with this window slot for the pattern's length.
    logic [BYTE_W-1:0] r_al  [NP];

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win <= i_byte;
        end
        if (i_raw_wr.en && (32'(i_pos) == POS)) begin
            r_raw[i_raw_wr.idx[PIW-1:0]] <= i_raw_wr.data;
        end
        if (i_al_wr.en) begin
            r_al[i_al_wr.idx[PIW-1:0]] <= i_al_wr.data;
        end
    end

    assign o_byte = r_win;
    assign o_raw  = r_raw[i_rd_idx[PIW-1:0]];

    // Slots beyond a pattern's length do not take part in its compare.
    always_comb begin
        for (int p = 0; p < NP; p++) begin
            o_ok[p] = (LW'(POS) >= i_alen[p]) || (r_al[p] == r_win);
        end
    end

endmodule

@@ rtl/mpbm_align.sv @@
module mpbm_align
    import mpbm_pkg::*;
#(
    parameter int M  = 64,
    parameter int LW = 7
) (
    input  logic [M-1:0][BYTE_W-1:0] i_row,
    input  logic [LW-1:0]            i_len,
    output logic [M-1:0][BYTE_W-1:0] o_row
);

    logic [M*BYTE_W-1:0] rev;
    logic [LW-1:0]       shamt;

    // Slot j of the window must meet pattern byte len-1-j: reverse the row,
    // then shift it down by the unused tail.
    always_comb begin
        for (int i = 0; i < M; i++) begin
            rev[i*BYTE_W +: BYTE_W] = i_row[M-1-i];
        end
    end

    assign shamt = LW'(M) - i_len;
    assign o_row = rev >> {shamt, 3'b000};

endmodule
